[src/appx_pkg.sv]
`timescale 1ns / 1ps

package appx_pkg;

   localparam int MAP_DEPTH  = 256;
   localparam int MAP_ADDR_W = 8;
   localparam int PIX_W      = 8;
   localparam int AMP_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int COUNT_W    = 9;

   localparam logic [1:0] CMD_CONVERT    = 2'd0;
   localparam logic [1:0] CMD_LOAD_COLOR = 2'd1;
   localparam logic [1:0] CMD_LOAD_MAP   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_AMP_MIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMP_MAX     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTIGUOUS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_COUNT = 3'd4;

   localparam logic [AMP_W-1:0]   AMP_MIN_RST     = 32'd0;
   localparam logic [AMP_W-1:0]   AMP_MAX_RST     = 32'd65536;
   localparam logic [AMP_W-1:0]   SCALE_RST       = 32'd16646144;
   localparam logic [COUNT_W-1:0] COLOR_COUNT_RST = 9'd256;

   localparam logic [63:0] HALF_Q32     = 64'h0000_0000_8000_0000;
   localparam logic [63:0] ONE_HALF_Q32 = 64'h0000_0001_8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MUL,
      ST_LEVEL,
      ST_MAP,
      ST_COLOR,
      ST_SEARCH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [PIX_W-1:0] color;
      logic [PIX_W-1:0] pick;
   } token_type;

endpackage

[src/appx_ram.sv]
`timescale 1ns / 1ps

module appx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/appx_cell.sv]
`timescale 1ns / 1ps

module appx_cell
   import appx_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [PIX_W-1:0] wr_value,
   input  logic             pair_live,
   input  logic [PIX_W-1:0] next_entry,
   output logic [PIX_W-1:0] entry,
   input  token_type        tok_in,
   output token_type        tok_out
);

   logic [PIX_W-1:0] entry_ff, entry_in;
   token_type        tok_ff, tok_fwd_in;
   logic [PIX_W-1:0] below, above;
   logic             hit;

   always_comb begin
      entry_in = wr_en ? wr_value : entry_ff;
      below    = tok_in.color - entry_ff;
      above    = next_entry - tok_in.color;
      hit      = tok_in.valid && !tok_in.found && pair_live
                 && (tok_in.color >= entry_ff) && (tok_in.color <= next_entry);
      tok_fwd_in = tok_in;
      if (hit) begin
         tok_fwd_in.found = 1'b1;
         tok_fwd_in.pick  = (below < above) ? entry_ff : next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_fwd_in;
      end
   end

   assign entry   = entry_ff;
   assign tok_out = tok_ff;

endmodule

[src/amplitude_to_palette_pixel_core.sv]
`timescale 1ns / 1ps

// Channel  | Ports                                   | Moves
// req      | req_valid / req_stall, five fields      | one command per transfer
// rsp      | rsp_valid / rsp_stall, pixel, flag      | one pixel per convert
// csr      | csr_wr_en, csr_index, csr_wdata         | one register write
//
// A load is written while the core stays idle. A convert in contiguous mode
// steps through DIFF, MUL, LEVEL, MAP and COLOR to DONE; otherwise the palette
// search then passes a token through COLOR_DEPTH registered cells in turn.
// One command is in progress at a time; req_stall is high meanwhile.
// A waiting result is held under rsp_stall while the next command is taken.
// Reset is synchronous; table contents are undefined until loaded.

module amplitude_to_palette_pixel_core
   import appx_pkg::*;
#(
   parameter int COLOR_DEPTH = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic [7:0]              req_entry_index,
   input  logic [7:0]              req_entry_value,
   input  logic signed [AMP_W-1:0] req_sample,
   input  logic [7:0]              req_background_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_pixel,
   output logic                    rsp_used_background,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CIDX_W = (COLOR_DEPTH > 1) ? $clog2(COLOR_DEPTH) : 1;

   logic signed [AMP_W-1:0] amp_min_ff, amp_min_in;
   logic signed [AMP_W-1:0] amp_max_ff, amp_max_in;
   logic [AMP_W-1:0]        scale_ff, scale_in;
   logic                    contiguous_ff, contiguous_in;
   logic [COUNT_W-1:0]      color_count_ff, color_count_in;

   state_type               state_ff, state_in;
   logic signed [AMP_W-1:0] sample_ff, sample_in;
   logic [PIX_W-1:0]        bg_ff, bg_in;
   logic                    neg_ff, neg_in;
   logic [AMP_W-1:0]        mag_ff, mag_in;
   logic [63:0]             prod_ff, prod_in;
   logic [PIX_W-1:0]        res_pixel_ff, res_pixel_in;
   logic                    res_bg_ff, res_bg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]        rsp_pixel_ff, rsp_pixel_in;
   logic                    rsp_bg_ff, rsp_bg_in;

   logic                    req_accept;
   logic                    color_load;
   logic                    map_load;
   logic signed [AMP_W-1:0] smp_lo, smp_cl;
   logic [AMP_W:0]          diff, diff_abs;
   logic [63:0]             mul_out;
   logic [64:0]             round_sum;
   logic [32:0]             level_int;
   logic [PIX_W-1:0]        level;
   logic [PIX_W-1:0]        map_rd_data;
   logic [PIX_W-1:0]        color_rd_data;
   logic [CIDX_W-1:0]       color_rd_addr;
   logic                    launch;

   token_type               tok [COLOR_DEPTH+1];
   logic [PIX_W-1:0]        cell_entry [COLOR_DEPTH];

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign color_load = req_accept && (req_command == CMD_LOAD_COLOR)
                       && (int'(req_entry_index) < COLOR_DEPTH);
   assign map_load   = req_accept && (req_command == CMD_LOAD_MAP);

   always_comb begin
      amp_min_in     = amp_min_ff;
      amp_max_in     = amp_max_ff;
      scale_in       = scale_ff;
      contiguous_in  = contiguous_ff;
      color_count_in = color_count_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_AMP_MIN:     amp_min_in     = csr_wdata;
            CSR_AMP_MAX:     amp_max_in     = csr_wdata;
            CSR_SCALE:       scale_in       = csr_wdata;
            CSR_CONTIGUOUS:  contiguous_in  = csr_wdata[0];
            CSR_COLOR_COUNT: color_count_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      smp_lo    = (sample_ff < amp_min_ff) ? amp_min_ff : sample_ff;
      smp_cl    = (smp_lo > amp_max_ff) ? amp_max_ff : smp_lo;
      diff      = {smp_cl[AMP_W-1], smp_cl} - {amp_min_ff[AMP_W-1], amp_min_ff};
      diff_abs  = diff[AMP_W] ? ((AMP_W+1)'(0) - diff) : diff;
      mul_out   = 64'(scale_ff) * 64'(mag_ff);
      round_sum = {1'b0, prod_ff} + {1'b0, ONE_HALF_Q32};
      level_int = round_sum[64:32];
      if (neg_ff) begin
         level = (prod_ff <= HALF_Q32) ? 8'd1 : 8'd0;
      end else begin
         level = (level_int > 33'd255) ? 8'd255 : level_int[7:0];
      end
      if (int'(map_rd_data) >= COLOR_DEPTH) begin
         color_rd_addr = CIDX_W'(COLOR_DEPTH - 1);
      end else begin
         color_rd_addr = map_rd_data[CIDX_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      bg_in        = bg_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      res_pixel_in = res_pixel_ff;
      res_bg_in    = res_bg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_bg_in    = rsp_bg_ff;
      launch       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_command == CMD_CONVERT)) begin
               sample_in = req_sample;
               bg_in     = req_background_pixel;
               state_in  = ST_DIFF;
            end
         end
         ST_DIFF: begin
            neg_in   = diff[AMP_W];
            mag_in   = diff_abs[AMP_W-1:0];
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = mul_out;
            state_in = ST_LEVEL;
         end
         ST_LEVEL: begin
            state_in = ST_MAP;
         end
         ST_MAP: begin
            state_in = ST_COLOR;
         end
         ST_COLOR: begin
            if (contiguous_ff) begin
               res_pixel_in = color_rd_data;
               res_bg_in    = 1'b0;
               state_in     = ST_DONE;
            end else begin
               launch   = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tok[COLOR_DEPTH].valid) begin
               if (tok[COLOR_DEPTH].found) begin
                  res_pixel_in = tok[COLOR_DEPTH].pick;
                  res_bg_in    = 1'b0;
               end else begin
                  res_pixel_in = bg_ff;
                  res_bg_in    = 1'b1;
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = res_pixel_ff;
               rsp_bg_in    = res_bg_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_min_ff     <= AMP_MIN_RST;
         amp_max_ff     <= AMP_MAX_RST;
         scale_ff       <= SCALE_RST;
         contiguous_ff  <= 1'b1;
         color_count_ff <= COLOR_COUNT_RST;
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         amp_min_ff     <= amp_min_in;
         amp_max_ff     <= amp_max_in;
         scale_ff       <= scale_in;
         contiguous_ff  <= contiguous_in;
         color_count_ff <= color_count_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      bg_ff        <= bg_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      prod_ff      <= prod_in;
      res_pixel_ff <= res_pixel_in;
      res_bg_ff    <= res_bg_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_bg_ff    <= rsp_bg_in;
   end

   appx_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAP_DEPTH)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (map_load),
      .wr_addr (req_entry_index[MAP_ADDR_W-1:0]),
      .wr_data (req_entry_value),
      .rd_addr (level),
      .rd_data (map_rd_data)
   );

   appx_ram #(
      .WIDTH (PIX_W),
      .DEPTH (COLOR_DEPTH)
   ) u_color_ram (
      .clock   (clock),
      .wr_en   (color_load),
      .wr_addr (req_entry_index[CIDX_W-1:0]),
      .wr_data (req_entry_value),
      .rd_addr (color_rd_addr),
      .rd_data (color_rd_data)
   );

   assign tok[0] = '{valid: launch, found: 1'b0, color: color_rd_data, pick: '0};

   for (genvar k = 0; k < COLOR_DEPTH; k++) begin : g_cell
      logic [PIX_W-1:0] next_entry;
      logic             pair_live;
      logic             cell_wr;

      if (k < COLOR_DEPTH - 1) begin : g_mid
         assign next_entry = cell_entry[k+1];
         assign pair_live  = (int'(color_count_ff) > k + 1);
      end else begin : g_last
         assign next_entry = '0;
         assign pair_live  = 1'b0;
      end

      assign cell_wr = color_load && (int'(req_entry_index) == k);

      appx_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (cell_wr),
         .wr_value   (req_entry_value),
         .pair_live  (pair_live),
         .next_entry (next_entry),
         .entry      (cell_entry[k]),
         .tok_in     (tok[k]),
         .tok_out    (tok[k+1])
      );
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pixel           = rsp_pixel_ff;
   assign rsp_used_background = rsp_bg_ff;

endmodule
